// ----- rtl/core/dtq_pkg.sv -----
// ---------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the drop-tail queue
// Holds the channel payload types, the configuration register map and
// reset values, the opcode codes and the sequencer state type.
// ---------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

  // Fixed field widths of the channels and registers.
  localparam int LEN_W      = 16;
  localparam int BYTE_W     = 24;
  localparam int PKT_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Opcodes of an input transaction.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PACKET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_PACKET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BYTE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_BYTE    = 3'd6;

  // Configuration reset values.
  localparam logic              RST_COUNT_MODE  = 1'b0;
  localparam logic [PKT_W-1:0]  RST_MAX_PACKET  = 8'd100;
  localparam logic [BYTE_W-1:0] RST_MAX_BYTE    = 24'd6553500;
  localparam logic [PKT_W-1:0]  RST_HIGH_PACKET = 8'd80;
  localparam logic [PKT_W-1:0]  RST_LOW_PACKET  = 8'd50;
  localparam logic [BYTE_W-1:0] RST_HIGH_BYTE   = 24'd5242800;
  localparam logic [BYTE_W-1:0] RST_LOW_BYTE    = 24'd3276750;

  // Input transaction payload.
  typedef struct packed {
    logic             opcode;
    logic [LEN_W-1:0] packet_length;
    logic             bypass;
  } dtq_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic              accepted;
    logic              dropped;
    logic              high_event;
    logic              low_event;
    logic              congested;
    logic [PKT_W-1:0]  packet_total;
    logic [BYTE_W-1:0] byte_total;
    logic [LEN_W-1:0]  dequeued_length;
    logic              was_empty;
  } dtq_out_t;

  // Configuration register bank as seen by the datapath.
  typedef struct packed {
    logic              count_mode;
    logic [PKT_W-1:0]  max_packet_limit;
    logic [BYTE_W-1:0] max_byte_limit;
    logic [PKT_W-1:0]  high_packet_level;
    logic [PKT_W-1:0]  low_packet_level;
    logic [BYTE_W-1:0] high_byte_level;
    logic [BYTE_W-1:0] low_byte_level;
  } dtq_cfg_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } dtq_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/dtq_in_if.sv -----
// ---------------------------------------------------------------------------
// dtq_in_if: input channel of the drop-tail queue
// Valid/ready channel that carries one enqueue or dequeue request.
// ---------------------------------------------------------------------------
`default_nettype none

interface dtq_in_if;
  logic             valid;
  logic             ready;
  dtq_pkg::dtq_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dtq_out_if.sv -----
// ---------------------------------------------------------------------------
// dtq_out_if: result channel of the drop-tail queue
// Valid/ready channel that carries one result per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface dtq_out_if;
  logic              valid;
  logic              ready;
  dtq_pkg::dtq_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dtq_cfg.sv -----
// ---------------------------------------------------------------------------
// dtq_cfg: configuration register bank
// Seven write-only registers loaded through a plain indexed write port.
// ---------------------------------------------------------------------------
`default_nettype none

module dtq_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [dtq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dtq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output dtq_pkg::dtq_cfg_t                     cfg
);

  dtq_pkg::dtq_cfg_t cfg_r;
  dtq_pkg::dtq_cfg_t cfg_nxt;

  // Decode the write index; indexes beyond the map are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        dtq_pkg::CFG_COUNT_MODE:  cfg_nxt.count_mode        = cfg_wdata[0];
        dtq_pkg::CFG_MAX_PACKET:  cfg_nxt.max_packet_limit  = cfg_wdata[dtq_pkg::PKT_W-1:0];
        dtq_pkg::CFG_MAX_BYTE:    cfg_nxt.max_byte_limit    = cfg_wdata[dtq_pkg::BYTE_W-1:0];
        dtq_pkg::CFG_HIGH_PACKET: cfg_nxt.high_packet_level = cfg_wdata[dtq_pkg::PKT_W-1:0];
        dtq_pkg::CFG_LOW_PACKET:  cfg_nxt.low_packet_level  = cfg_wdata[dtq_pkg::PKT_W-1:0];
        dtq_pkg::CFG_HIGH_BYTE:   cfg_nxt.high_byte_level   = cfg_wdata[dtq_pkg::BYTE_W-1:0];
        dtq_pkg::CFG_LOW_BYTE:    cfg_nxt.low_byte_level    = cfg_wdata[dtq_pkg::BYTE_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register bank with its reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count_mode        <= dtq_pkg::RST_COUNT_MODE;
      cfg_r.max_packet_limit  <= dtq_pkg::RST_MAX_PACKET;
      cfg_r.max_byte_limit    <= dtq_pkg::RST_MAX_BYTE;
      cfg_r.high_packet_level <= dtq_pkg::RST_HIGH_PACKET;
      cfg_r.low_packet_level  <= dtq_pkg::RST_LOW_PACKET;
      cfg_r.high_byte_level   <= dtq_pkg::RST_HIGH_BYTE;
      cfg_r.low_byte_level    <= dtq_pkg::RST_LOW_BYTE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/core/dtq_mem.sv -----
// ---------------------------------------------------------------------------
// dtq_mem: packet length store
// Simple dual-port synchronous memory, one write and one registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module dtq_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] store_mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= store_mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/core/dtq_ctrl.sv -----
// ---------------------------------------------------------------------------
// dtq_ctrl: queue sequencer and occupancy datapath
// Holds the pointers, totals and congestion flags, reads and writes the
// length store, and registers one result per request.
// ---------------------------------------------------------------------------
`default_nettype none

module dtq_ctrl #(
  parameter int QUEUE_DEPTH = 128,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  dtq_in_if.sink                              in_ch,
  dtq_out_if.source                           out_ch,
  input  dtq_pkg::dtq_cfg_t                   cfg,
  output logic                                mem_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0]      mem_waddr,
  output logic [LENGTH_BITS-1:0]              mem_wdata,
  output logic                                mem_re,
  output logic [$clog2(QUEUE_DEPTH)-1:0]      mem_raddr,
  input  wire logic [LENGTH_BITS-1:0]         mem_rdata
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W  = dtq_pkg::LEN_W;
  localparam int BYTE_W = dtq_pkg::BYTE_W;
  localparam int PKT_W  = dtq_pkg::PKT_W;
  localparam int EFF_W  = (LENGTH_BITS < LEN_W) ? LENGTH_BITS : LEN_W;
  localparam int SUM_W  = BYTE_W + 1;
  localparam int OCC_W  = (CNT_W > SUM_W) ? CNT_W : SUM_W;
  localparam int DW     = (LENGTH_BITS > BYTE_W) ? LENGTH_BITS : BYTE_W;
  localparam int PW     = (CNT_W > PKT_W) ? CNT_W : PKT_W;
  localparam int OW     = (LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // Control state.
  dtq_pkg::dtq_state_t state_r, state_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic                high_r, high_nxt;
  logic                low_r, low_nxt;
  logic                out_valid_r;

  // Payload registers.
  dtq_pkg::dtq_in_t    item_r;
  dtq_pkg::dtq_out_t   out_data_r;
  dtq_pkg::dtq_out_t   res;

  // Handshake and sequencing.
  logic in_ready;
  logic accept;
  logic out_free;
  logic done;

  // Datapath intermediates.
  logic [EFF_W-1:0]  len_eff;
  logic [SUM_W-1:0]  prosp;
  logic [OCC_W-1:0]  occ;
  logic [OCC_W-1:0]  hi_lv;
  logic [OCC_W-1:0]  lo_lv;
  logic              hi_cond;
  logic              lo_cond;
  logic              high_mid;
  logic              low_mid;
  logic              limit_hit;
  logic              drop;
  logic              is_enq;
  logic              is_empty;
  logic [DW-1:0]     deq_ext;
  logic [DW-1:0]     byte_ext;
  logic [BYTE_W-1:0] byte_after_deq;
  logic [PW-1:0]     cnt_ext;
  logic [OW-1:0]     deq_out;

  assign accept   = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dtq_pkg::ST_IDLE: if (accept) state_nxt = dtq_pkg::ST_EXEC;
      dtq_pkg::ST_EXEC: if (out_free) state_nxt = dtq_pkg::ST_IDLE;
      default:          state_nxt = dtq_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    done     = 1'b0;
    unique case (state_r)
      dtq_pkg::ST_IDLE: in_ready = 1'b1;
      dtq_pkg::ST_EXEC: done     = out_free;
      default: begin
        in_ready = 1'b0;
        done     = 1'b0;
      end
    endcase
  end

  // Enqueue arithmetic: prospective byte total and occupancy selection.
  assign is_enq  = (item_r.opcode == dtq_pkg::OP_ENQ);
  assign len_eff = item_r.packet_length[EFF_W-1:0];
  assign prosp   = {1'b0, byte_r} + SUM_W'(len_eff);
  assign occ     = cfg.count_mode ? OCC_W'(prosp) : OCC_W'(cnt_r);
  assign hi_lv   = cfg.count_mode ? OCC_W'(cfg.high_byte_level)
                                  : OCC_W'(cfg.high_packet_level);
  assign lo_lv   = cfg.count_mode ? OCC_W'(cfg.low_byte_level)
                                  : OCC_W'(cfg.low_packet_level);
  assign cnt_ext = PW'(cnt_r);

  // Hysteresis: the high check runs first, the low check sees its outcome.
  assign hi_cond  = (occ >= hi_lv) && !high_r;
  assign high_mid = hi_cond ? 1'b1 : high_r;
  assign low_mid  = hi_cond ? 1'b0 : low_r;
  assign lo_cond  = (occ <= lo_lv) && !low_mid && high_mid;

  // Drop decision: limit (unless bypass), physically full, or byte overflow.
  assign limit_hit = cfg.count_mode ? (prosp >= SUM_W'(cfg.max_byte_limit))
                                    : (cnt_ext >= PW'(cfg.max_packet_limit));
  assign drop = (limit_hit && !item_r.bypass) || (cnt_r >= CNT_FULL) || prosp[BYTE_W];

  // Dequeue arithmetic: the byte total saturates at zero.
  assign is_empty       = (cnt_r == '0);
  assign deq_ext        = DW'(mem_rdata);
  assign byte_ext       = DW'(byte_r);
  assign byte_after_deq = (byte_ext >= deq_ext) ? BYTE_W'(byte_ext - deq_ext) : '0;
  assign deq_out        = OW'(mem_rdata);

  // State update and result assembly for the request in flight.
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    byte_nxt = byte_r;
    high_nxt = high_r;
    low_nxt  = low_r;
    res      = '0;
    if (is_enq) begin
      high_nxt       = lo_cond ? 1'b0 : high_mid;
      low_nxt        = lo_cond ? 1'b1 : low_mid;
      res.high_event = hi_cond;
      res.low_event  = lo_cond;
      if (drop) begin
        res.dropped = 1'b1;
      end else begin
        res.accepted = 1'b1;
        tail_nxt     = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        byte_nxt     = prosp[BYTE_W-1:0];
      end
    end else begin
      if (is_empty) begin
        res.was_empty = 1'b1;
      end else begin
        res.dequeued_length = deq_out[LEN_W-1:0];
        head_nxt            = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
        cnt_nxt             = cnt_r - 1'b1;
        byte_nxt            = byte_after_deq;
      end
    end
    res.congested    = high_nxt;
    res.packet_total = PW'(cnt_nxt) & PW'({PKT_W{1'b1}});
    res.byte_total   = byte_nxt;
  end

  // Length store accesses: read the head on a dequeue, write the tail on store.
  assign mem_re    = accept && (in_ch.data.opcode == dtq_pkg::OP_DEQ);
  assign mem_raddr = head_r;
  assign mem_we    = done && is_enq && !drop;
  assign mem_waddr = tail_r;
  assign mem_wdata = LENGTH_BITS'(len_eff);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtq_pkg::ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      byte_r      <= '0;
      high_r      <= 1'b0;
      low_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done) begin
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        cnt_r       <= cnt_nxt;
        byte_r      <= byte_nxt;
        high_r      <= high_nxt;
        low_r       <= low_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_ch.data;
    end
    if (done) begin
      out_data_r <= res;
    end
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // The packet count never exceeds the store depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("packet count above queue depth");

  // The two hysteresis flags are never set together.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(high_r && low_r))
    else $error("high and low flags both set");

  // Queue state only moves when a request completes.
  a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dtq_pkg::ST_IDLE) |=> $stable(cnt_r) && $stable(byte_r) &&
                                      $stable(head_r) && $stable(tail_r))
    else $error("queue state changed while idle");

  // A completed enqueue is either stored or dropped, never both.
  a_enq_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    (done && is_enq) |-> (res.accepted != res.dropped))
    else $error("enqueue outcome inconsistent");

endmodule

`default_nettype wire

// ----- rtl/core/drop_tail_queue_congestion_flags.sv -----
// ---------------------------------------------------------------------------
// drop_tail_queue_congestion_flags: drop-tail queue with congestion flags
//
// Channels: in_ch takes one request per transaction (enqueue a packet
// length, or dequeue the head packet); out_ch returns exactly one result
// per request, in request order. The cfg_* port writes the seven limit and
// level registers one index at a time; write them only while no request is
// outstanding.
// Sequencing: a request is taken in ST_IDLE, which issues the read of the
// head entry in the length store on a dequeue; ST_EXEC then applies the
// update, writes the store and registers the result, once no earlier
// result is still waiting on out_ch. No new request is taken until the
// last one has completed.
// Reset: totals, pointers and flags clear to zero and the registers take
// their default values; store contents stay undefined, as only held
// entries are ever used. No clearing pass is needed.
// Stall: while out_ch is stalled a new request is still accepted, but it
// completes only after the waiting result has been taken.
// ---------------------------------------------------------------------------
`default_nettype none

module drop_tail_queue_congestion_flags #(
  parameter int QUEUE_DEPTH = 128,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  dtq_in_if.sink                                in_ch,
  dtq_out_if.source                             out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [dtq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dtq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  dtq_pkg::dtq_cfg_t      cfg;
  logic                   mem_we;
  logic [PTR_W-1:0]       mem_waddr;
  logic [LENGTH_BITS-1:0] mem_wdata;
  logic                   mem_re;
  logic [PTR_W-1:0]       mem_raddr;
  logic [LENGTH_BITS-1:0] mem_rdata;

  // Configuration registers.
  dtq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Packet length store.
  dtq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (LENGTH_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer, totals and congestion flags.
  dtq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg       (cfg),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ----- tb/sv/drop_tail_queue_congestion_flags_test.sv -----
// ---------------------------------------------------------------------------
// drop_tail_queue_congestion_flags_test: self-checking bench of the queue
// Drives enqueue and dequeue transactions into the drop-tail queue, first
// from a short directed table and then in random phases under several
// register settings. A shadow queue with its own totals and flags predicts
// every result, which is compared field by field in request order.
// ---------------------------------------------------------------------------
`default_nettype none

module drop_tail_queue_congestion_flags_test;

  localparam int QUEUE_DEPTH   = 128;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 50;
  localparam int IDLE_PCT      = 16;

  // Index past the end of the register map; writes to it must be ignored.
  localparam logic [dtq_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  localparam dtq_pkg::dtq_out_t NO_WANT = '0;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  // One row of the directed table: a transaction or a register write.
  // The argument is the packet length of a transaction or the write data.
  typedef struct {
    row_kind_t                         kind;
    logic [dtq_pkg::CFG_IDX_W-1:0]     reg_idx;
    logic                              opcode;
    logic                              bypass;
    logic [dtq_pkg::CFG_DATA_W-1:0]    arg;
    logic                              typed;
    dtq_pkg::dtq_out_t                 want;
  } plan_row_t;

  // One random phase: register settings and the traffic mix.
  typedef struct {
    dtq_pkg::dtq_cfg_t cfg;
    int unsigned       items;
    int unsigned       enq_pct;
    int unsigned       bypass_pct;
    logic              idle_on;
  } phase_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [dtq_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dtq_pkg::CFG_DATA_W-1:0] cfg_wdata;

  logic              sink_ready = 1'b0;
  logic              stall_on = 1'b1;
  logic              source_idle_on = 1'b1;
  logic              req_typed;
  dtq_pkg::dtq_out_t req_want;

  dtq_in_if  in_ch ();
  dtq_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  drop_tail_queue_congestion_flags #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LENGTH_BITS (dtq_pkg::LEN_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Directed table: reset state, length extremes, limit drops, both events
  // on one enqueue, byte mode at its extremes and the unlisted register.
  plan_row_t directed_plan [31] = '{
    '{ROW_REQ, '0, dtq_pkg::OP_DEQ, 1'b0, 24'd0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 24'd0, 16'd0, 1'b1}},
    '{ROW_REQ, '0, dtq_pkg::OP_ENQ, 1'b0, 24'd0, 1'b1,
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd1, 24'd0, 16'd0, 1'b0}},
    '{ROW_REQ, '0, dtq_pkg::OP_ENQ, 1'b1, 24'd65535, 1'b1,
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd2, 24'd65535, 16'd0, 1'b0}},
    '{ROW_REQ, '0, dtq_pkg::OP_DEQ, 1'b0, 24'd0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd1, 24'd65535, 16'd0, 1'b0}},
    '{ROW_REQ, '0, dtq_pkg::OP_DEQ, 1'b0, 24'd0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 24'd0, 16'd65535, 1'b0}},
    '{ROW_CFG, dtq_pkg::CFG_MAX_PACKET, '0, 1'b0, 24'd0, 1'b0, NO_WANT},
    '{ROW_REQ, '0, dtq_pkg::OP_ENQ, 1'b0, 24'd100, 1'b1,
      '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 24'd0, 16'd0, 1'b0}},
    '{ROW_REQ, '0, dtq_pkg::OP_ENQ, 1'b1, 24'd200, 1'b1,
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd1, 24'd200, 16'd0, 1'b0}},
    '{ROW_CFG, dtq_pkg::CFG_HIGH_PACKET, '0, 1'b0, 24'd0, 1'b0, NO_WANT},
    '{ROW_CFG, dtq_pkg::CFG_LOW_PACKET, '0, 1'b0, 24'd0, 1'b0, NO_WANT},
    '{ROW_CFG, dtq_pkg::CFG_MAX_PACKET, '0, 1'b0, 24'd128, 1'b0, NO_WANT},
    '{ROW_REQ, '0, dtq_pkg::OP_ENQ, 1'b0, 24'd5, 1'b0, NO_WANT},
    '{ROW_REQ, '0, dtq_pkg::OP_DEQ, 1'b0, 24'd0, 1'b0, NO_WANT},
    '{ROW_REQ, '0, dtq_pkg::OP_DEQ, 1'b1, 24'd0, 1'b0, NO_WANT},
    '{ROW_REQ, '0, dtq_pkg::OP_ENQ, 1'b0, 24'd7, 1'b0, NO_WANT},
    '{ROW_REQ, '0, dtq_pkg::OP_DEQ, 1'b0, 24'd0, 1'b0, NO_WANT},
    '{ROW_REQ, '0, dtq_pkg::OP_ENQ, 1'b1, 24'd9, 1'b0, NO_WANT},
    '{ROW_CFG, dtq_pkg::CFG_COUNT_MODE, '0, 1'b0, 24'd1, 1'b0, NO_WANT},
    '{ROW_CFG, dtq_pkg::CFG_MAX_BYTE, '0, 1'b0, 24'hFFFFFF, 1'b0, NO_WANT},
    '{ROW_CFG, dtq_pkg::CFG_HIGH_BYTE, '0, 1'b0, 24'hFFFFFF, 1'b0, NO_WANT},
    '{ROW_CFG, dtq_pkg::CFG_LOW_BYTE, '0, 1'b0, 24'd0, 1'b0, NO_WANT},
    '{ROW_REQ, '0, dtq_pkg::OP_ENQ, 1'b0, 24'd65535, 1'b0, NO_WANT},
    '{ROW_REQ, '0, dtq_pkg::OP_ENQ, 1'b1, 24'd65535, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_SPARE, '0, 1'b0, 24'hFFFFFF, 1'b0, NO_WANT},
    '{ROW_CFG, dtq_pkg::CFG_MAX_BYTE, '0, 1'b0, 24'd0, 1'b0, NO_WANT},
    '{ROW_REQ, '0, dtq_pkg::OP_ENQ, 1'b0, 24'd1, 1'b0, NO_WANT},
    '{ROW_REQ, '0, dtq_pkg::OP_ENQ, 1'b1, 24'd1, 1'b0, NO_WANT},
    '{ROW_REQ, '0, dtq_pkg::OP_DEQ, 1'b0, 24'd0, 1'b0, NO_WANT},
    '{ROW_REQ, '0, dtq_pkg::OP_DEQ, 1'b0, 24'd0, 1'b0, NO_WANT},
    '{ROW_REQ, '0, dtq_pkg::OP_DEQ, 1'b0, 24'd0, 1'b0, NO_WANT},
    '{ROW_REQ, '0, dtq_pkg::OP_DEQ, 1'b0, 24'd0, 1'b0, NO_WANT}
  };

  // Random phases. The second fills the queue to its physical depth with
  // no idling on either side, the third restores the reset values and
  // drains it again, and the last two run the registers at their extremes.
  phase_t phase_plan [6] = '{
    '{'{1'b0, 8'd16, dtq_pkg::RST_MAX_BYTE, 8'd12, 8'd4,
        dtq_pkg::RST_HIGH_BYTE, dtq_pkg::RST_LOW_BYTE},
      150, 55, 25, 1'b1},
    '{'{1'b0, 8'd128, 24'hFFFFFF, 8'd128, 8'd0, 24'hFFFFFF, 24'hFFFFFF},
      250, 85, 50, 1'b0},
    '{'{dtq_pkg::RST_COUNT_MODE, dtq_pkg::RST_MAX_PACKET, dtq_pkg::RST_MAX_BYTE,
        dtq_pkg::RST_HIGH_PACKET, dtq_pkg::RST_LOW_PACKET,
        dtq_pkg::RST_HIGH_BYTE, dtq_pkg::RST_LOW_BYTE},
      250, 30, 20, 1'b1},
    '{'{1'b1, 8'd16, 24'd1500000, 8'd12, 8'd4, 24'd1000000, 24'd400000},
      150, 45, 25, 1'b1},
    '{'{1'b1, 8'd0, 24'd0, 8'd0, 8'd0, 24'd0, 24'd0},
      100, 50, 50, 1'b1},
    '{'{1'b0, 8'd0, 24'd0, 8'd0, 8'd128, 24'd0, 24'd0},
      100, 50, 50, 1'b1}
  };

  // Shadow of the queue: held lengths, byte total, flags and registers.
  logic [dtq_pkg::LEN_W-1:0]  held_lengths [$];
  logic [dtq_pkg::BYTE_W-1:0] held_bytes = '0;
  logic                       congested_flag = 1'b0;
  logic                       cleared_flag = 1'b0;
  dtq_pkg::dtq_cfg_t          shadow_cfg;
  dtq_pkg::dtq_out_t          pending_outcomes [$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned result_index = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Computes the outcome of one request and advances the shadow queue.
  // The congestion checks come before the drop decision.
  function automatic dtq_pkg::dtq_out_t predict_queue_step(dtq_pkg::dtq_in_t req);
    dtq_pkg::dtq_out_t          res;
    int                         held_count;
    logic [dtq_pkg::BYTE_W:0]   prospective;
    logic [dtq_pkg::BYTE_W:0]   occupancy;
    logic [dtq_pkg::BYTE_W:0]   high_level;
    logic [dtq_pkg::BYTE_W:0]   low_level;
    logic                       limit_hit;
    logic [dtq_pkg::LEN_W-1:0]  popped;
    res = '0;
    held_count = held_lengths.size();
    if (req.opcode == dtq_pkg::OP_ENQ) begin
      prospective = held_bytes + req.packet_length;
      if (shadow_cfg.count_mode) begin
        occupancy  = prospective;
        high_level = shadow_cfg.high_byte_level;
        low_level  = shadow_cfg.low_byte_level;
        limit_hit  = prospective >= shadow_cfg.max_byte_limit;
      end else begin
        occupancy  = held_count;
        high_level = shadow_cfg.high_packet_level;
        low_level  = shadow_cfg.low_packet_level;
        limit_hit  = held_count >= shadow_cfg.max_packet_limit;
      end
      if (occupancy >= high_level && !congested_flag) begin
        res.high_event = 1'b1;
        congested_flag = 1'b1;
        cleared_flag   = 1'b0;
      end
      if (occupancy <= low_level && !cleared_flag && congested_flag) begin
        res.low_event  = 1'b1;
        cleared_flag   = 1'b1;
        congested_flag = 1'b0;
      end
      // The carry bit marks a byte total past 24 bits; at this depth it
      // cannot be reached, but the rule is kept.
      if ((limit_hit && !req.bypass) || held_count >= QUEUE_DEPTH ||
          prospective[dtq_pkg::BYTE_W]) begin
        res.dropped = 1'b1;
      end else begin
        held_lengths.push_back(req.packet_length);
        held_bytes   = prospective[dtq_pkg::BYTE_W-1:0];
        res.accepted = 1'b1;
      end
    end else if (held_count == 0) begin
      res.was_empty = 1'b1;
    end else begin
      popped = held_lengths.pop_front();
      held_bytes = (held_bytes >= popped) ? held_bytes - popped : '0;
      res.dequeued_length = popped;
    end
    res.congested    = congested_flag;
    res.packet_total = held_lengths.size();
    res.byte_total   = held_bytes;
    return res;
  endfunction

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("cycle %0d: %s", cycle_count, what);
    end
  endtask

  task automatic check_field(input int unsigned seq, input string field,
                             input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                seq, field, got, want));
    end
  endtask

  // Scoreboard: mirrors register writes, predicts each accepted request
  // and checks each accepted result against the oldest expectation.
  always @(posedge clk) begin : scoreboard
    dtq_pkg::dtq_out_t got;
    dtq_pkg::dtq_out_t want;
    if (!rst_n) begin
      held_lengths.delete();
      pending_outcomes.delete();
      held_bytes     = '0;
      congested_flag = 1'b0;
      cleared_flag   = 1'b0;
      shadow_cfg     = '{dtq_pkg::RST_COUNT_MODE, dtq_pkg::RST_MAX_PACKET,
                         dtq_pkg::RST_MAX_BYTE, dtq_pkg::RST_HIGH_PACKET,
                         dtq_pkg::RST_LOW_PACKET, dtq_pkg::RST_HIGH_BYTE,
                         dtq_pkg::RST_LOW_BYTE};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dtq_pkg::CFG_COUNT_MODE:
            shadow_cfg.count_mode        = cfg_wdata[0];
          dtq_pkg::CFG_MAX_PACKET:
            shadow_cfg.max_packet_limit  = cfg_wdata[dtq_pkg::PKT_W-1:0];
          dtq_pkg::CFG_MAX_BYTE:
            shadow_cfg.max_byte_limit    = cfg_wdata[dtq_pkg::BYTE_W-1:0];
          dtq_pkg::CFG_HIGH_PACKET:
            shadow_cfg.high_packet_level = cfg_wdata[dtq_pkg::PKT_W-1:0];
          dtq_pkg::CFG_LOW_PACKET:
            shadow_cfg.low_packet_level  = cfg_wdata[dtq_pkg::PKT_W-1:0];
          dtq_pkg::CFG_HIGH_BYTE:
            shadow_cfg.high_byte_level   = cfg_wdata[dtq_pkg::BYTE_W-1:0];
          dtq_pkg::CFG_LOW_BYTE:
            shadow_cfg.low_byte_level    = cfg_wdata[dtq_pkg::BYTE_W-1:0];
          default: ;
        endcase
      end
      // Results first: a request accepted at this edge cannot have one yet.
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_outcomes.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    result_index));
        end else begin
          want = pending_outcomes.pop_front();
          check_field(result_index, "accepted", got.accepted, want.accepted);
          check_field(result_index, "dropped", got.dropped, want.dropped);
          check_field(result_index, "high_event", got.high_event, want.high_event);
          check_field(result_index, "low_event", got.low_event, want.low_event);
          check_field(result_index, "congested", got.congested, want.congested);
          check_field(result_index, "packet_total", got.packet_total,
                      want.packet_total);
          check_field(result_index, "byte_total", got.byte_total, want.byte_total);
          check_field(result_index, "dequeued_length", got.dequeued_length,
                      want.dequeued_length);
          check_field(result_index, "was_empty", got.was_empty, want.was_empty);
        end
        result_index++;
      end
      if (in_ch.valid && in_ch.ready) begin
        want = predict_queue_step(in_ch.data);
        pending_outcomes.push_back(req_typed ? req_want : want);
      end
    end
  end

  // Result side: stalls at random while the current phase allows it.
  always @(posedge clk) begin
    sink_ready <= !(stall_on && ($urandom_range(0, 99) < IDLE_PCT));
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one transaction, after an optional random gap, and returns at
  // the edge where it is taken.
  task automatic send_request(input dtq_pkg::dtq_in_t req, input logic typed,
                              input dtq_pkg::dtq_out_t want);
    if (source_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 25);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= req;
    req_typed   <= typed;
    req_want    <= want;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Holds off new requests until every expected result has been taken,
  // then lets the block settle.
  task automatic drain_queue();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dtq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dtq_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stimulus: reset, directed table, random phases, final drain.
  initial begin : stimulus
    dtq_pkg::dtq_in_t req;
    phase_t           ph;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    req_typed   = 1'b0;
    req_want    = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    rst_n       = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows; register writes wait until the block is idle.
    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_CFG) begin
        drain_queue();
        write_reg(directed_plan[r].reg_idx, directed_plan[r].arg);
      end else begin
        req.opcode        = directed_plan[r].opcode;
        req.packet_length = directed_plan[r].arg[dtq_pkg::LEN_W-1:0];
        req.bypass        = directed_plan[r].bypass;
        send_request(req, directed_plan[r].typed, directed_plan[r].want);
      end
    end

    // Random phases, each with a pause for a full drain halfway through.
    foreach (phase_plan[p]) begin
      ph = phase_plan[p];
      drain_queue();
      write_reg(dtq_pkg::CFG_COUNT_MODE, ph.cfg.count_mode);
      write_reg(dtq_pkg::CFG_MAX_PACKET, ph.cfg.max_packet_limit);
      write_reg(dtq_pkg::CFG_MAX_BYTE, ph.cfg.max_byte_limit);
      write_reg(dtq_pkg::CFG_HIGH_PACKET, ph.cfg.high_packet_level);
      write_reg(dtq_pkg::CFG_LOW_PACKET, ph.cfg.low_packet_level);
      write_reg(dtq_pkg::CFG_HIGH_BYTE, ph.cfg.high_byte_level);
      write_reg(dtq_pkg::CFG_LOW_BYTE, ph.cfg.low_byte_level);
      source_idle_on = ph.idle_on;
      stall_on      <= ph.idle_on;
      for (int k = 0; k < ph.items; k++) begin
        if (k == ph.items / 2) drain_queue();
        req.opcode = ($urandom_range(0, 99) < ph.enq_pct) ? dtq_pkg::OP_ENQ
                                                          : dtq_pkg::OP_DEQ;
        case ($urandom_range(0, 9))
          0:       req.packet_length = '0;
          1:       req.packet_length = '1;
          default: req.packet_length = $urandom_range(0, 65535);
        endcase
        req.bypass = $urandom_range(0, 99) < ph.bypass_pct;
        send_request(req, 1'b0, NO_WANT);
      end
    end

    drain_queue();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/dtq_pkg.sv
rtl/core/dtq_in_if.sv
rtl/core/dtq_out_if.sv
rtl/core/dtq_cfg.sv
rtl/core/dtq_mem.sv
rtl/core/dtq_ctrl.sv
rtl/core/drop_tail_queue_congestion_flags.sv
tb/sv/drop_tail_queue_congestion_flags_test.sv
